>>> rtl/core/bpt_pkg.sv
// bpt_pkg: shared types, constants and the microprogram of the balance pid core
// used by bpt_cfg, bpt_seq, bpt_dp and balance_pid_with_tilt_cutoff_core
// no dependencies
package bpt_pkg;

  localparam int GAIN_W   = 24;
  localparam int ANGLE_W  = 16;
  localparam int LIMIT_W  = 15;
  localparam int ILIM_W   = 23;
  localparam int CIDX_W   = 3;
  localparam int CDATA_W  = 24;
  localparam int GAIN_SHIFT = 16;
  // error after feed-forward correction, integrator, accumulator, product
  localparam int ERR_W    = 18;
  localparam int DIFF_W   = 19;
  localparam int INTEG_W  = 24;
  localparam int Y_W      = 29;
  localparam int MA_W     = 25;
  localparam int PROD_W   = MA_W + DIFF_W;
  localparam int SH_W     = PROD_W - GAIN_SHIFT;
  localparam int STEP_W   = 4;

  // 0.015 as a q0.16 constant
  localparam logic [GAIN_W-1:0] FEED_FACTOR = 24'd983;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_KP             = 3'd0;
  localparam logic [CIDX_W-1:0] REG_KI             = 3'd1;
  localparam logic [CIDX_W-1:0] REG_KD             = 3'd2;
  localparam logic [CIDX_W-1:0] REG_TARGET_ANGLE   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
  localparam logic [CIDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd5;
  localparam logic [CIDX_W-1:0] REG_TILT_LIMIT     = 3'd6;
  localparam logic [CIDX_W-1:0] REG_DEAD_BAND      = 3'd7;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_ERR,
    ALU_FEED,
    ALU_INTEG,
    ALU_YKP,
    ALU_YKD,
    ALU_CLAMP,
    ALU_OUT
  } alu_op_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_FEED,
    MUL_KI,
    MUL_KP,
    MUL_KD
  } mul_sel_t;

  typedef enum logic {
    COND_NEVER,
    COND_SMALL_DRIVE
  } cond_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    alu_op_t  alu;
    mul_sel_t mul;
    cond_t    cond;
    step_t    target;
    logic     done;
  } ucode_t;

  typedef struct packed {
    logic   load;
    logic   exec;
    ucode_t cw;
  } ctl_t;

  typedef struct packed {
    logic small_drive;
  } sts_t;

  typedef struct packed {
    logic [GAIN_W-1:0]         kp;
    logic [GAIN_W-1:0]         ki;
    logic [GAIN_W-1:0]         kd;
    logic signed [ANGLE_W-1:0] target_angle;
    logic [ILIM_W-1:0]         integral_limit;
    logic [LIMIT_W-1:0]        output_limit;
    logic [LIMIT_W-1:0]        tilt_limit;
    logic [LIMIT_W-1:0]        dead_band;
  } cfg_t;

  localparam step_t STEP_KI   = 4'd3;
  localparam step_t LAST_STEP = 4'd8;

  // microprogram: one control word per step
  function automatic ucode_t ucode(input step_t s);
    ucode_t w;
    w = '{alu: ALU_NOP, mul: MUL_NONE, cond: COND_NEVER, target: '0, done: 1'b0};
    case (s)
      4'd0: begin
        w.alu = ALU_ERR;
        w.mul = MUL_FEED;
      end
      4'd1: begin
        // keep the feed product in the register for the next step
        w.mul    = MUL_FEED;
        w.cond   = COND_SMALL_DRIVE;
        w.target = STEP_KI;
      end
      4'd2: begin
        w.alu = ALU_FEED;
      end
      4'd3: begin
        w.mul = MUL_KI;
      end
      4'd4: begin
        w.alu = ALU_INTEG;
        w.mul = MUL_KP;
      end
      4'd5: begin
        w.alu = ALU_YKP;
        w.mul = MUL_KD;
      end
      4'd6: begin
        w.alu = ALU_YKD;
      end
      4'd7: begin
        w.alu = ALU_CLAMP;
      end
      4'd8: begin
        w.alu  = ALU_OUT;
        w.done = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [Y_W-1:0] clampsym(input logic signed [Y_W-1:0] x,
                                                      input logic [Y_W-1:0] lim);
    logic signed [Y_W-1:0] l;
    l = $signed(lim);
    if (x > l) return l;
    if (x < -l) return -l;
    return x;
  endfunction

endpackage

>>> rtl/core/balance_pid_with_tilt_cutoff_core.sv
// balance_pid_with_tilt_cutoff_core: top level of the balance pid controller with tilt cut-off
// depends on bpt_pkg, bpt_cfg, bpt_seq, bpt_dp
//
//   channel  handshake               payload
//   in       in_valid / in_ready     pitch_angle
//   out      out_valid / out_ready   drive, tipped
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// a sample runs the microprogram from transfer to the result register, skipping the feed
// step when the previous drive is within ten degrees; its steps share one multiplier
// one sample is in flight at a time; in_ready is high only while the sequencer is idle,
// so the next transfer comes at the earliest in the cycle after the result register loads
// a result waiting on out_ready holds the final step, earlier steps run on
// synchronous reset clears controller state and loads the register defaults
module balance_pid_with_tilt_cutoff_core #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [bpt_pkg::ANGLE_W-1:0]  pitch_angle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bpt_pkg::ANGLE_W-1:0]  drive,
  output logic                                tipped,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpt_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [bpt_pkg::CDATA_W-1:0]         cfg_data
);

  bpt_pkg::cfg_t cfg;
  bpt_pkg::ctl_t ctl;
  bpt_pkg::sts_t sts;

  bpt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  bpt_dp #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cfg         (cfg),
    .pitch_angle (pitch_angle),
    .sts         (sts),
    .drive       (drive),
    .tipped      (tipped)
  );

endmodule

>>> rtl/core/bpt_cfg.sv
// bpt_cfg: configuration register file of the balance pid core
// depends on bpt_pkg
module bpt_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpt_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [bpt_pkg::CDATA_W-1:0]   cfg_data,
  output bpt_pkg::cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp             <= 24'd189923;
      cfg.ki             <= 24'd66;
      cfg.kd             <= 24'd353;
      cfg.target_angle   <= 16'sd256;
      cfg.integral_limit <= 23'd640000;
      cfg.output_limit   <= 15'd12800;
      cfg.tilt_limit     <= 15'd7680;
      cfg.dead_band      <= 15'd512;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpt_pkg::REG_KP:             cfg.kp             <= cfg_data;
        bpt_pkg::REG_KI:             cfg.ki             <= cfg_data;
        bpt_pkg::REG_KD:             cfg.kd             <= cfg_data;
        bpt_pkg::REG_TARGET_ANGLE:   cfg.target_angle   <= $signed(cfg_data[15:0]);
        bpt_pkg::REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data[22:0];
        bpt_pkg::REG_OUTPUT_LIMIT:   cfg.output_limit   <= cfg_data[14:0];
        bpt_pkg::REG_TILT_LIMIT:     cfg.tilt_limit     <= cfg_data[14:0];
        bpt_pkg::REG_DEAD_BAND:      cfg.dead_band      <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/bpt_seq.sv
// bpt_seq: microcode sequencer, step counter, jumps and output handshake
// depends on bpt_pkg
module bpt_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bpt_pkg::sts_t sts,
  output bpt_pkg::ctl_t ctl
);

  bpt_pkg::seq_state_t state, state_next;
  bpt_pkg::step_t      step, step_next;
  bpt_pkg::ucode_t     cw;
  logic                finish;

  assign cw = bpt_pkg::ucode(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpt_pkg::SEQ_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    finish     = 1'b0;
    in_ready   = (state == bpt_pkg::SEQ_IDLE);
    ctl.load   = 1'b0;
    ctl.exec   = 1'b0;
    ctl.cw     = cw;
    case (state)
      bpt_pkg::SEQ_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = bpt_pkg::SEQ_RUN;
          step_next  = '0;
        end
      end
      bpt_pkg::SEQ_RUN: begin
        if (cw.done) begin
          // last step commits only when the output register is free
          if (!out_valid || out_ready) begin
            ctl.exec   = 1'b1;
            finish     = 1'b1;
            state_next = bpt_pkg::SEQ_IDLE;
          end
        end else begin
          ctl.exec = 1'b1;
          if (cw.cond == bpt_pkg::COND_SMALL_DRIVE && sts.small_drive) begin
            step_next = cw.target;
          end else begin
            step_next = step + 4'd1;
          end
        end
      end
      default: begin
        state_next = bpt_pkg::SEQ_IDLE;
      end
    endcase
  end

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid)
    else $error("result not presented after final step");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == bpt_pkg::SEQ_RUN && step == '0))
    else $error("accepted sample did not start the program");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == bpt_pkg::SEQ_RUN) |-> (step <= bpt_pkg::LAST_STEP))
    else $error("step counter ran past the program");

endmodule

>>> rtl/core/bpt_dp.sv
// bpt_dp: datapath with the shared gain multiplier, controller state and result registers
// depends on bpt_pkg
module bpt_dp #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bpt_pkg::ctl_t                       ctl,
  input  bpt_pkg::cfg_t                       cfg,
  input  logic signed [bpt_pkg::ANGLE_W-1:0]  pitch_angle,
  output bpt_pkg::sts_t                       sts,
  output logic signed [bpt_pkg::ANGLE_W-1:0]  drive,
  output logic                                tipped
);

  localparam int Ten = 10 << ANGLE_FRAC_BITS;

  logic signed [bpt_pkg::ANGLE_W-1:0]  p;
  logic signed [bpt_pkg::ERR_W-1:0]    e;
  logic signed [bpt_pkg::ERR_W-1:0]    prev_e;
  logic signed [bpt_pkg::ANGLE_W-1:0]  prev_drive;
  logic signed [bpt_pkg::INTEG_W-1:0]  integ;
  logic signed [bpt_pkg::Y_W-1:0]      y;
  logic signed [bpt_pkg::PROD_W-1:0]   prod;
  logic                                tip;

  logic signed [bpt_pkg::MA_W-1:0]     mul_a;
  logic signed [bpt_pkg::DIFF_W-1:0]   mul_b;
  logic signed [bpt_pkg::SH_W-1:0]     prod_sh;
  logic signed [31:0]                  drive_ext;
  logic signed [bpt_pkg::Y_W-1:0]      ilim;
  logic signed [bpt_pkg::Y_W-1:0]      integ_sum;
  logic signed [bpt_pkg::ANGLE_W:0]    tl;
  logic signed [bpt_pkg::INTEG_W:0]    y_narrow;
  logic signed [bpt_pkg::INTEG_W:0]    band_hi;
  logic signed [bpt_pkg::INTEG_W:0]    band_lo;
  logic signed [bpt_pkg::INTEG_W:0]    y_gated;
  logic signed [bpt_pkg::Y_W-1:0]      y_final;
  logic signed [bpt_pkg::ANGLE_W-1:0]  drive_d;

  // feed-forward correction only beyond ten degrees of previous drive
  assign drive_ext       = 32'(prev_drive);
  assign sts.small_drive = !(drive_ext > Ten || drive_ext < -Ten);

  // arithmetic shift of the product by the gain fraction
  assign prod_sh = prod[bpt_pkg::PROD_W-1:bpt_pkg::GAIN_SHIFT];

  always_comb begin
    case (ctl.cw.mul)
      bpt_pkg::MUL_FEED: begin
        mul_a = $signed({1'b0, bpt_pkg::FEED_FACTOR});
        mul_b = bpt_pkg::DIFF_W'(prev_drive);
      end
      bpt_pkg::MUL_KI: begin
        mul_a = $signed({1'b0, cfg.ki});
        mul_b = bpt_pkg::DIFF_W'(e);
      end
      bpt_pkg::MUL_KP: begin
        mul_a = $signed({1'b0, cfg.kp});
        mul_b = bpt_pkg::DIFF_W'(e);
      end
      bpt_pkg::MUL_KD: begin
        mul_a = $signed({1'b0, cfg.kd});
        mul_b = bpt_pkg::DIFF_W'(e) - bpt_pkg::DIFF_W'(prev_e);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign ilim      = $signed({{(bpt_pkg::Y_W - bpt_pkg::ILIM_W){1'b0}}, cfg.integral_limit});
  assign integ_sum = bpt_pkg::Y_W'(integ) + bpt_pkg::Y_W'(prod_sh);
  assign tl        = $signed({2'b00, cfg.tilt_limit});

  // dead band is compared against the output itself, not the pitch
  assign y_narrow = y[bpt_pkg::INTEG_W:0];
  assign band_hi  = (bpt_pkg::INTEG_W + 1)'(cfg.target_angle)
                    + $signed({10'd0, cfg.dead_band});
  assign band_lo  = (bpt_pkg::INTEG_W + 1)'(cfg.target_angle)
                    - $signed({10'd0, cfg.dead_band});
  assign y_gated  = ((y_narrow < band_hi && y_narrow > band_lo) || tip) ? '0 : y_narrow;
  assign y_final  = bpt_pkg::clampsym(bpt_pkg::Y_W'(y_gated),
                      {{(bpt_pkg::Y_W - bpt_pkg::LIMIT_W){1'b0}}, cfg.output_limit});
  assign drive_d  = y_final[bpt_pkg::ANGLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      integ      <= '0;
      prev_e     <= '0;
      prev_drive <= '0;
    end else if (ctl.exec) begin
      case (ctl.cw.alu)
        bpt_pkg::ALU_INTEG: integ <= bpt_pkg::INTEG_W'(bpt_pkg::clampsym(integ_sum,
                                       {{(bpt_pkg::Y_W - bpt_pkg::ILIM_W){1'b0}},
                                        cfg.integral_limit}));
        bpt_pkg::ALU_YKD:   prev_e <= e;
        bpt_pkg::ALU_OUT: begin
          prev_drive <= drive_d;
          if (tip) begin
            integ <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      p <= pitch_angle;
    end
    if (ctl.exec) begin
      prod <= mul_a * mul_b;
      case (ctl.cw.alu)
        bpt_pkg::ALU_ERR: begin
          e   <= bpt_pkg::ERR_W'(p) - bpt_pkg::ERR_W'(cfg.target_angle);
          tip <= ((bpt_pkg::ANGLE_W + 1)'(p) > tl) || ((bpt_pkg::ANGLE_W + 1)'(p) < -tl);
        end
        bpt_pkg::ALU_FEED:  e <= e + $signed(prod[bpt_pkg::GAIN_SHIFT+bpt_pkg::ERR_W-1:
                                                   bpt_pkg::GAIN_SHIFT]);
        bpt_pkg::ALU_YKP:   y <= bpt_pkg::Y_W'(prod_sh) + bpt_pkg::Y_W'(integ);
        bpt_pkg::ALU_YKD:   y <= y + bpt_pkg::Y_W'(prod_sh);
        bpt_pkg::ALU_CLAMP: y <= bpt_pkg::clampsym(y, ilim);
        bpt_pkg::ALU_OUT: begin
          drive  <= drive_d;
          tipped <= tip;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> tb/balance_pid_with_tilt_cutoff_core_tb.sv
// balance_pid_with_tilt_cutoff_core_tb: self-checking bench for the balance pid core
// drives pitch samples and register writes, predicts drive and tipped per sample
// depends on bpt_pkg and balance_pid_with_tilt_cutoff_core
module balance_pid_with_tilt_cutoff_core_tb;
  import bpt_pkg::*;

  localparam int FRAC = 8;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 180;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] drive;
    logic                      tipped;
  } drive_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [ANGLE_W-1:0] pitch_angle = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [ANGLE_W-1:0] drive;
  logic                      tipped;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CIDX_W-1:0]         cfg_index = '0;
  logic [CDATA_W-1:0]        cfg_data = '0;

  // predictor copy of the registers and controller state
  cfg_t   active_cfg;
  longint integ_acc;
  longint last_error;
  longint last_drive;

  drive_result_t pending_results[$];
  drive_result_t expected_out;
  cfg_t          plan;
  int            mismatches = 0;
  int            ready_hold = 0;
  int            walk = 0;
  bit            no_stalls = 1'b0;

  balance_pid_with_tilt_cutoff_core #(
    .ANGLE_FRAC_BITS(FRAC)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pitch_angle(pitch_angle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .drive(drive),
    .tipped(tipped),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic cfg_t reset_settings();
    cfg_t s;
    s.kp             = 24'd189923;
    s.ki             = 24'd66;
    s.kd             = 24'd353;
    s.target_angle   = 16'sd256;
    s.integral_limit = 23'd640000;
    s.output_limit   = 15'd12800;
    s.tilt_limit     = 15'd7680;
    s.dead_band      = 15'd512;
    return s;
  endfunction

  function automatic longint clamp_to(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // one controller update; advances the predictor state
  function automatic drive_result_t balance_step(input logic signed [ANGLE_W-1:0] pitch);
    longint        p;
    longint        sp;
    longint        err;
    longint        y;
    longint        band;
    longint        tl;
    longint        ten;
    drive_result_t r;
    p    = pitch;
    sp   = active_cfg.target_angle;
    band = longint'(active_cfg.dead_band);
    tl   = longint'(active_cfg.tilt_limit);
    ten  = longint'(10) << FRAC;
    err  = p - sp;
    if (last_drive > ten || last_drive < -ten)
      err = err + ((last_drive * longint'(FEED_FACTOR)) >>> GAIN_SHIFT);
    integ_acc = clamp_to(integ_acc + ((longint'(active_cfg.ki) * err) >>> GAIN_SHIFT),
                         longint'(active_cfg.integral_limit));
    y = ((longint'(active_cfg.kp) * err) >>> GAIN_SHIFT) + integ_acc
        + ((longint'(active_cfg.kd) * (err - last_error)) >>> GAIN_SHIFT);
    y = clamp_to(y, longint'(active_cfg.integral_limit));
    last_error = err;
    // the band test looks at the output itself, not at the pitch
    if (y < sp + band && y > sp - band) y = 0;
    r.tipped = (p > tl || p < -tl);
    if (r.tipped) begin
      y = 0;
      integ_acc = 0;
    end
    y = clamp_to(y, longint'(active_cfg.output_limit));
    last_drive = y;
    r.drive = y[ANGLE_W-1:0];
    return r;
  endfunction

  function automatic int unsigned pick_value(input int unsigned top, input int unsigned typical);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return top;
      6, 7: return $urandom_range(0, top);
      default: return $urandom_range(0, typical);
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    s.kp             = 24'(pick_value(24'hffffff, 1 << 20));
    s.ki             = 24'(pick_value(24'hffffff, 4096));
    s.kd             = 24'(pick_value(24'hffffff, 1 << 16));
    s.integral_limit = 23'(pick_value(23'h7fffff, 1000000));
    s.output_limit   = 15'(pick_value(15'h7fff, 16000));
    s.tilt_limit     = 15'(pick_value(15'h7fff, 12000));
    s.dead_band      = 15'(pick_value(15'h7fff, 2048));
    case ($urandom_range(0, 7))
      0: s.target_angle = 16'sh8000;
      1: s.target_angle = 16'sh7fff;
      6, 7: s.target_angle = 16'($urandom);
      default: s.target_angle = 16'(int'($urandom_range(0, 4096)) - 2048);
    endcase
    return s;
  endfunction

  // mostly a slow walk inside the tilt window so the integrator builds up
  function automatic logic signed [ANGLE_W-1:0] next_pitch();
    int          v;
    int          tl;
    int unsigned mode;
    tl   = int'(active_cfg.tilt_limit);
    mode = $urandom_range(0, 19);
    if (mode < 14) begin
      walk = walk + int'($urandom_range(0, 600)) - 300;
      if (walk > tl + 256 || walk < -tl - 256) begin
        walk = int'(active_cfg.target_angle);
        if (walk > tl || walk < -tl) walk = 0;
      end
      v = walk;
    end else if (mode < 17) begin
      v = tl + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1) == 1) v = -v;
    end else if (mode < 19) begin
      v = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      v = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("mismatch at %0t: %s", $time, what);
  endtask

  // valid stays high after a transfer unless a gap follows
  task automatic send_pitch(input logic signed [ANGLE_W-1:0] value);
    if (!no_stalls && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pitch_angle <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(balance_step(value));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // writes all eight registers back to back, junk in the unused upper bits
  task automatic load_settings(input cfg_t s);
    logic [CDATA_W-1:0] words [8];
    logic [CIDX_W-1:0]  order [8];
    logic [31:0]        junk;
    junk     = $urandom;
    order    = '{REG_KP, REG_KI, REG_KD, REG_TARGET_ANGLE, REG_INTEGRAL_LIMIT,
                 REG_OUTPUT_LIMIT, REG_TILT_LIMIT, REG_DEAD_BAND};
    words[0] = s.kp;
    words[1] = s.ki;
    words[2] = s.kd;
    words[3] = {junk[7:0], s.target_angle};
    words[4] = {junk[8], s.integral_limit};
    words[5] = {junk[17:9], s.output_limit};
    words[6] = {junk[26:18], s.tilt_limit};
    words[7] = {junk[31:27], junk[3:0], s.dead_band};
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= words[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (order[i])
        REG_KP:             active_cfg.kp = words[i];
        REG_KI:             active_cfg.ki = words[i];
        REG_KD:             active_cfg.kd = words[i];
        REG_TARGET_ANGLE:   active_cfg.target_angle = words[i][ANGLE_W-1:0];
        REG_INTEGRAL_LIMIT: active_cfg.integral_limit = words[i][ILIM_W-1:0];
        REG_OUTPUT_LIMIT:   active_cfg.output_limit = words[i][LIMIT_W-1:0];
        REG_TILT_LIMIT:     active_cfg.tilt_limit = words[i][LIMIT_W-1:0];
        REG_DEAD_BAND:      active_cfg.dead_band = words[i][LIMIT_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // register defaults straight out of reset, field extremes, tilt edges
  task automatic test_reset_defaults();
    send_pitch(16'sd0);
    send_pitch(16'sd256);
    send_pitch(16'sh7fff);
    send_pitch(16'sh8000);
    send_pitch(16'sd7680);
    send_pitch(-16'sd7680);
    send_pitch(16'sd7681);
    send_pitch(-16'sd7681);
    send_pitch(16'sd767);
    send_pitch(-16'sd255);
  endtask

  // previous drive pinned exactly at ten degrees, then one lsb beyond
  task automatic test_feed_threshold();
    drain();
    plan = reset_settings();
    plan.output_limit = 15'd2560;
    plan.dead_band = '0;
    load_settings(plan);
    send_pitch(16'sd5000);
    send_pitch(16'sd5000);
    send_pitch(-16'sd5000);
    send_pitch(-16'sd5000);
    drain();
    plan.output_limit = 15'd2561;
    load_settings(plan);
    send_pitch(16'sd5000);
    send_pitch(16'sd5000);
    send_pitch(-16'sd5000);
    send_pitch(-16'sd5000);
  endtask

  task automatic test_zero_limits();
    drain();
    plan = reset_settings();
    plan.integral_limit = '0;
    plan.output_limit = '0;
    plan.dead_band = '0;
    load_settings(plan);
    send_pitch(16'sd1000);
    send_pitch(-16'sd1000);
    send_pitch(16'sd3000);
    drain();
    // no dead band: tiny outputs around the setpoint come through
    plan = reset_settings();
    plan.dead_band = '0;
    load_settings(plan);
    send_pitch(16'sd256);
    send_pitch(16'sd257);
    send_pitch(16'sd255);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == 0) begin
        plan = '{kp: '1, ki: '1, kd: '1, target_angle: 16'sh7fff,
                 integral_limit: '1, output_limit: '1, tilt_limit: '1, dead_band: '1};
      end else if (ph == 1) begin
        plan = '0;
        plan.target_angle = 16'sh8000;
      end else if (ph == 2) begin
        plan = reset_settings();
      end else begin
        plan = random_settings();
      end
      load_settings(plan);
      walk = int'(active_cfg.target_angle);
      // last phase runs without gaps on either side
      if (ph == PHASES - 1) no_stalls = 1'b1;
      repeat (PHASE_ITEMS) send_pitch(next_pitch());
    end
  endtask

  // receiver stalls in bursts, ready runs of random length in between
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!no_stalls && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 15);
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 15);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("drive %0d transfer with no sample pending", drive));
      end else begin
        expected_out = pending_results.pop_front();
        if (drive !== expected_out.drive)
          report_mismatch($sformatf("drive %0d, expected %0d", drive, expected_out.drive));
        if (tipped !== expected_out.tipped)
          report_mismatch($sformatf("tipped %b, expected %b", tipped, expected_out.tipped));
      end
    end
  end

  initial begin
    active_cfg = reset_settings();
    integ_acc  = 0;
    last_error = 0;
    last_drive = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_feed_threshold();
    test_zero_limits();
    test_random_phases();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** balance_pid_with_tilt_cutoff_core: PASSED **");
    end else begin
      $display("** balance_pid_with_tilt_cutoff_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("** balance_pid_with_tilt_cutoff_core: FAILED **");
    $finish;
  end

endmodule
